/* rtl/core/dic_pkg.sv */
// Shared types and constants of the DPCM image codec.
`timescale 1ns / 1ps
`default_nettype none

package dic_pkg;

  localparam int PIX_W          = 8;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int WIDTH_REG_W    = 11;
  localparam int HEIGHT_REG_W   = 16;
  localparam int QUANT_REG_W    = 4;
  localparam int WEIGHT_W       = 12;
  localparam int FRAC_BITS      = 8;
  localparam int DEF_MAX_WIDTH  = 1024;

  // Register indexes of the configuration channel.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CODEC_MODE   = 3'd0,
    REG_IMAGE_WIDTH  = 3'd1,
    REG_IMAGE_HEIGHT = 3'd2,
    REG_QUANT_BITS   = 3'd3,
    REG_WEIGHT_L     = 3'd4,
    REG_WEIGHT_A     = 3'd5,
    REG_WEIGHT_UL    = 3'd6
  } cfg_reg_t;

  // Codec direction.
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // Register reset values.
  localparam logic [WIDTH_REG_W-1:0]  RST_IMAGE_WIDTH  = 11'd256;
  localparam logic [HEIGHT_REG_W-1:0] RST_IMAGE_HEIGHT = 16'd256;
  localparam logic [QUANT_REG_W-1:0]  RST_QUANT_BITS   = 4'd8;
  localparam logic [WEIGHT_W-1:0]     RST_WEIGHT_L     = 12'd256;
  localparam logic [WEIGHT_W-1:0]     RST_WEIGHT_A     = 12'd0;
  localparam logic [WEIGHT_W-1:0]     RST_WEIGHT_UL    = 12'd0;

  // Which predictor a pixel uses, fixed by its position in the image.
  typedef enum logic [1:0] {
    PRED_RAW   = 2'd0,
    PRED_LEFT  = 2'd1,
    PRED_ABOVE = 2'd2,
    PRED_MIX   = 2'd3
  } pred_kind_t;

  // Control that travels with an item from the input stage to the compute stage.
  typedef struct packed {
    pred_kind_t kind;
    logic       pass;   // beyond the image: forwarded unchanged, no state update
    logic       fwd;    // above pixel was written in the cycle it was read
  } s1_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/dic_if.sv */
// Stream and configuration channel interfaces of the DPCM image codec.
`timescale 1ns / 1ps
`default_nettype none

interface dic_in_if;
  logic                     valid;
  logic                     ready;
  logic [dic_pkg::PIX_W-1:0] sample_in;
  logic                     frame_start;
  modport source (output valid, output sample_in, output frame_start, input ready);
  modport sink   (input valid, input sample_in, input frame_start, output ready);
endinterface

interface dic_out_if;
  logic                     valid;
  logic                     ready;
  logic [dic_pkg::PIX_W-1:0] sample_out;
  logic                     passed_raw;
  modport source (output valid, output sample_out, output passed_raw, input ready);
  modport sink   (input valid, input sample_out, input passed_raw, output ready);
endinterface

interface dic_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dic_pkg::CFG_IDX_W-1:0]  index;
  logic [dic_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/dpcm_image_codec.sv */
// Top level of the DPCM image codec with a three-neighbor predictor.
`timescale 1ns / 1ps
`default_nettype none

// The codec takes one pixel (encode) or one code (decode) per transaction in
// raster order and returns exactly one result transaction for each, in order.
// It sustains one transaction per clock while the output is not stalled: an item is
// registered together with the read of its above neighbor from the line store,
// and the compute stage then forms the prediction, quantization and
// reconstruction and loads them into the output register when it advances. The
// rate is set by the left-neighbor loop, which closes through the compute
// stage, and by the one read port of the line store. A
// result waiting in the output register does not block the input while the
// compute stage can drain into it. Registers are written through the
// configuration channel, which is always ready; they should only be changed
// while no transaction is in flight. Setting frame_start on an item restarts
// the image at that item. After image_height rows of image_width pixels, every
// further item passes unchanged with passed_raw set until the next frame
// start. The line store holds one row of reconstructed pixels of up to
// MAX_WIDTH entries and needs no clearing after reset.
module dpcm_image_codec #(
  parameter int MAX_WIDTH = dic_pkg::DEF_MAX_WIDTH
) (
  input wire logic clk,
  input wire logic rst,
  dic_cfg_if.sink  cfg,
  dic_in_if.sink   din,
  dic_out_if.source dout
);

  import dic_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
  localparam int WCMP_W = (CNT_W > WIDTH_REG_W) ? CNT_W : WIDTH_REG_W;
  localparam int PROD_W = WEIGHT_W + PIX_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  // Configuration registers.
  logic                     codec_mode;
  logic [WIDTH_REG_W-1:0]   image_width;
  logic [HEIGHT_REG_W-1:0]  image_height;
  logic [QUANT_REG_W-1:0]   quant_bits;
  logic signed [WEIGHT_W-1:0] weight_left;
  logic signed [WEIGHT_W-1:0] weight_above;
  logic signed [WEIGHT_W-1:0] weight_upper_left;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      codec_mode        <= MODE_ENCODE;
      image_width       <= RST_IMAGE_WIDTH;
      image_height      <= RST_IMAGE_HEIGHT;
      quant_bits        <= RST_QUANT_BITS;
      weight_left       <= RST_WEIGHT_L;
      weight_above      <= RST_WEIGHT_A;
      weight_upper_left <= RST_WEIGHT_UL;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_CODEC_MODE:   codec_mode        <= cfg.data[0];
        REG_IMAGE_WIDTH:  image_width       <= cfg.data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height      <= cfg.data[HEIGHT_REG_W-1:0];
        REG_QUANT_BITS:   quant_bits        <= cfg.data[QUANT_REG_W-1:0];
        REG_WEIGHT_L:     weight_left       <= cfg.data[WEIGHT_W-1:0];
        REG_WEIGHT_A:     weight_above      <= cfg.data[WEIGHT_W-1:0];
        REG_WEIGHT_UL:    weight_upper_left <= cfg.data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry and quantizer: zero widths and heights act as one, a
  // width above the line store saturates, and the quantizer is held to 1..8.
  logic [WCMP_W-1:0]       width_eff;
  logic [HEIGHT_REG_W-1:0] height_eff;
  logic [QUANT_REG_W-1:0]  quant_eff;
  logic [2:0]              shift;

  always_comb begin
    if (image_width == '0) begin
      width_eff = WCMP_W'(1);
    end else if (WCMP_W'(image_width) > WCMP_W'(MAX_WIDTH)) begin
      width_eff = WCMP_W'(MAX_WIDTH);
    end else begin
      width_eff = WCMP_W'(image_width);
    end
    height_eff = (image_height == '0) ? HEIGHT_REG_W'(1) : image_height;
    if (quant_bits == '0) begin
      quant_eff = QUANT_REG_W'(1);
    end else if (quant_bits inside {[4'd9:4'd15]}) begin
      quant_eff = QUANT_REG_W'(8);
    end else begin
      quant_eff = quant_bits;
    end
    shift = 3'(QUANT_REG_W'(8) - quant_eff);
  end

  // Pipeline handshake. The compute stage advances whenever the output
  // register is empty or being emptied; the input is taken whenever the
  // compute stage is empty or advancing.
  logic s1_valid;
  logic s1_go;
  logic in_fire;
  logic out_valid;

  assign s1_go     = !out_valid || dout.ready;
  assign din.ready = !s1_valid || s1_go;
  assign in_fire   = din.valid && din.ready;

  // Input stage: position counters advance as each transaction is accepted.
  logic [COL_W-1:0]        column_count;
  logic [HEIGHT_REG_W-1:0] row_count;
  logic                    image_done;

  logic [COL_W-1:0]        col_cur;
  logic [HEIGHT_REG_W-1:0] row_cur;
  logic                    done_cur;
  logic [WCMP_W-1:0]       col_inc;
  logic [HEIGHT_REG_W-1:0] row_inc;
  pred_kind_t              kind_cur;
  logic                    write_now;
  logic [COL_W-1:0]        s1_col;
  s1_ctl_t                 s1_ctl;
  logic [PIX_W-1:0]        s1_sample;

  always_comb begin
    col_cur  = din.frame_start ? '0 : column_count;
    row_cur  = din.frame_start ? '0 : row_count;
    done_cur = din.frame_start ? 1'b0 : image_done;
    col_inc  = WCMP_W'(col_cur) + WCMP_W'(1);
    row_inc  = row_cur + HEIGHT_REG_W'(1);
    if (row_cur == '0 && col_cur == '0) begin
      kind_cur = PRED_RAW;
    end else if (row_cur == '0) begin
      kind_cur = PRED_LEFT;
    end else if (col_cur == '0) begin
      kind_cur = PRED_ABOVE;
    end else begin
      kind_cur = PRED_MIX;
    end
  end

  // The compute stage writes its reconstruction in the same cycle that the
  // next item reads the line store; a hit on that address is forwarded.
  assign write_now = s1_valid && s1_go && !s1_ctl.pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      image_done   <= 1'b0;
    end else if (in_fire && !done_cur) begin
      if (col_inc >= width_eff) begin
        column_count <= '0;
        row_count    <= row_inc;
        image_done   <= (row_inc >= height_eff) || (row_inc == '0);
      end else begin
        column_count <= col_inc[COL_W-1:0];
        row_count    <= row_cur;
        image_done   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (din.ready) begin
      s1_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_col      <= col_cur;
      s1_sample   <= din.sample_in;
      s1_ctl.kind <= kind_cur;
      s1_ctl.pass <= done_cur;
      s1_ctl.fwd  <= write_now && (s1_col == col_cur);
    end
  end

  // Line store of reconstructed pixels from the row above.
  logic [PIX_W-1:0] line_rdata;
  logic [PIX_W-1:0] recon;

  dic_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (write_now),
    .waddr (s1_col),
    .wdata (recon),
    .re    (in_fire),
    .raddr (col_cur),
    .rdata (line_rdata)
  );

  // Compute stage: prediction, quantization and reconstruction.
  logic [PIX_W-1:0]         left_pixel;
  logic [PIX_W-1:0]         upper_left_pixel;
  logic [PIX_W-1:0]         above;
  logic signed [PIX_W:0]    left_s;
  logic signed [PIX_W:0]    above_s;
  logic signed [PIX_W:0]    ul_s;
  logic signed [PROD_W-1:0] prod_l;
  logic signed [PROD_W-1:0] prod_a;
  logic signed [PROD_W-1:0] prod_ul;
  logic [SUM_W-1:0]         sum;
  logic [PIX_W-1:0]         pred_mix;
  logic [PIX_W-1:0]         pred;
  logic [PIX_W-1:0]         diff;
  logic [PIX_W-1:0]         mask_hi;
  logic [PIX_W-1:0]         result;

  assign above   = s1_ctl.fwd ? left_pixel : line_rdata;
  assign left_s  = {1'b0, left_pixel};
  assign above_s = {1'b0, above};
  assign ul_s    = {1'b0, upper_left_pixel};
  assign prod_l  = weight_left * left_s;
  assign prod_a  = weight_above * above_s;
  assign prod_ul = weight_upper_left * ul_s;
  assign sum     = {{2{prod_l[PROD_W-1]}}, prod_l} + {{2{prod_a[PROD_W-1]}}, prod_a}
                 + {{2{prod_ul[PROD_W-1]}}, prod_ul};

  always_comb begin
    // Drop the fraction, then clamp to the pixel range.
    if (sum[SUM_W-1]) begin
      pred_mix = '0;
    end else if (|sum[SUM_W-2:FRAC_BITS+PIX_W]) begin
      pred_mix = '1;
    end else begin
      pred_mix = sum[FRAC_BITS+PIX_W-1:FRAC_BITS];
    end

    case (s1_ctl.kind)
      PRED_LEFT:  pred = left_pixel;
      PRED_ABOVE: pred = above;
      PRED_MIX:   pred = pred_mix;
      default:    pred = '0;
    endcase

    diff    = s1_sample - pred;
    mask_hi = PIX_W'({PIX_W{1'b1}} << shift);

    if (s1_ctl.kind == PRED_RAW) begin
      recon  = s1_sample;
      result = s1_sample;
    end else if (codec_mode == MODE_ENCODE) begin
      // The code keeps the top bits of the wrapped error; the decoder sees
      // the same bits back in place, so both sides reconstruct alike.
      recon  = pred + (diff & mask_hi);
      result = diff >> shift;
    end else begin
      recon  = pred + PIX_W'(s1_sample << shift);
      result = recon;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel       <= '0;
      upper_left_pixel <= '0;
    end else if (write_now) begin
      left_pixel       <= recon;
      upper_left_pixel <= above;
    end
  end

  // Output register.
  logic [PIX_W-1:0] out_sample;
  logic             out_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_valid) begin
      out_sample <= s1_ctl.pass ? s1_sample : result;
      out_raw    <= s1_ctl.pass || (s1_ctl.kind == PRED_RAW);
    end
  end

  assign dout.valid      = out_valid;
  assign dout.sample_out = out_sample;
  assign dout.passed_raw = out_raw;

endmodule

`default_nettype wire

/* rtl/core/dic_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module dic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
